[hw/rtl/multichannel_peak_level_meter_macros.svh]
// ----------------------------------------------------------------------------
// multichannel peak level meter assertion macros
// shared property forms for the concurrent checks of the meter
// ----------------------------------------------------------------------------
`ifndef MULTICHANNEL_PEAK_LEVEL_METER_MACROS_SVH
`define MULTICHANNEL_PEAK_LEVEL_METER_MACROS_SVH

// same-cycle implication, checked outside reset
`define MPLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define MPLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mplm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_pkg
// types and constants shared by the peak level meter modules
// ----------------------------------------------------------------------------
package mplm_pkg;

	// configuration register indexes
	localparam logic [2:0] CFG_CHANNEL_COUNT   = 3'd0;
	localparam logic [2:0] CFG_SAMPLE_BITS     = 3'd1;
	localparam logic [2:0] CFG_IS_SIGNED       = 3'd2;
	localparam logic [2:0] CFG_NUM_BLOCKS      = 3'd3;
	localparam logic [2:0] CFG_BLOCKS_PER_LOG2 = 3'd4;

	localparam int CFG_DATA_W = 24;

	// reset values of the configuration registers
	localparam logic [3:0]  RST_CHANNEL_COUNT   = 4'd2;
	localparam logic [5:0]  RST_SAMPLE_BITS     = 6'd16;
	localparam logic        RST_IS_SIGNED       = 1'b1;
	localparam logic [7:0]  RST_NUM_BLOCKS      = 8'd20;
	localparam logic [23:0] RST_BLOCKS_PER_LOG2 = 24'd87381;

	// legal raw sample widths
	localparam logic [5:0] MIN_SAMPLE_BITS = 6'd8;
	localparam logic [5:0] MAX_SAMPLE_BITS = 6'd32;

	// zone codes and their thresholds in percent of the bar
	localparam logic [1:0] ZONE_NORMAL = 2'd0;
	localparam logic [1:0] ZONE_YELLOW = 2'd1;
	localparam logic [1:0] ZONE_ORANGE = 2'd2;
	localparam logic [1:0] ZONE_RED    = 2'd3;
	localparam logic [6:0] PCT_YELLOW  = 7'd75;
	localparam logic [6:0] PCT_ORANGE  = 7'd83;
	localparam logic [6:0] PCT_RED     = 7'd91;
	localparam logic [6:0] PCT_FULL    = 7'd100;

	// report queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [3:0]  channel_count;
		logic [5:0]  sample_bits;
		logic        is_signed;
		logic [7:0]  num_blocks;
		logic [23:0] blocks_per_log2;
	} cfg_t;

	// one pending channel report
	typedef struct packed {
		logic [2:0]  channel;
		logic [31:0] peak;
		logic        last;
	} entry_t;

	typedef enum logic {
		FS_RUN,
		FS_DRAIN
	} front_state_t;

endpackage

[hw/rtl/mplm_sample_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_sample_if
// sample channel: one raw audio sample and its end of buffer mark
// ----------------------------------------------------------------------------
interface mplm_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample;
	logic        end_of_buffer;

	modport source (output valid, output sample, output end_of_buffer, input ready);
	modport sink (input valid, input sample, input end_of_buffer, output ready);
endinterface

[hw/rtl/mplm_report_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_report_if
// report channel: one per-channel level report
// ----------------------------------------------------------------------------
interface mplm_report_if;
	logic        valid;
	logic        ready;
	logic [2:0]  channel;
	logic [31:0] peak;
	logic [7:0]  lit_blocks;
	logic [1:0]  zone;
	logic        last;

	modport source (output valid, output channel, output peak, output lit_blocks,
		output zone, output last, input ready);
	modport sink (input valid, input channel, input peak, input lit_blocks,
		input zone, input last, output ready);
endinterface

[hw/rtl/mplm_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_queue
// short fifo of pending channel reports between front and back
// ----------------------------------------------------------------------------
module mplm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mplm_pkg::entry_t     push_data,
	input  logic                 pop,
	output mplm_pkg::entry_t     head,
	output logic                 full,
	output logic                 empty
);

	mplm_pkg::entry_t mem_q [mplm_pkg::QUEUE_DEPTH];
	logic [mplm_pkg::QUEUE_PW-1:0] wr_ptr_q;
	logic [mplm_pkg::QUEUE_PW-1:0] rd_ptr_q;
	logic [mplm_pkg::QUEUE_PW:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign full    = (count_q == (mplm_pkg::QUEUE_PW+1)'(mplm_pkg::QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/mplm_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_front
// takes samples, tracks per-channel peaks, drains them into the report queue
// ----------------------------------------------------------------------------
module mplm_front #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	mplm_sample_if.sink      samples,
	input  mplm_pkg::cfg_t   cfg,
	input  logic             clear_peaks,
	input  logic             q_full,
	output logic             q_push,
	output mplm_pkg::entry_t q_data
);

	localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	mplm_pkg::front_state_t state_q, state_d;

	logic [CW-1:0] idx_q;
	logic [CW-1:0] k_q;
	logic [31:0]   peak_q [MAX_CHANNELS];

	logic [31:0]   mag_s1;
	logic [CW-1:0] chan_s1;
	logic          eob_s1;
	logic          valid_s1;

	logic [CW:0]   n_used;
	logic [CW-1:0] c_cur;
	logic [CW:0]   c_inc;
	logic [CW-1:0] c_next;
	logic          k_last;
	logic          accept;
	logic          in_ready;

	logic [5:0]    bits_used;
	logic [32:0]   full_scale;
	logic [32:0]   half_scale;
	logic [32:0]   raw;
	logic [32:0]   mag;

	// channel count in use
	always_comb begin
		if (cfg.channel_count == '0) begin
			n_used = (CW+1)'(1);
		end else if (32'(cfg.channel_count) > 32'(MAX_CHANNELS)) begin
			n_used = (CW+1)'(MAX_CHANNELS);
		end else begin
			n_used = (CW+1)'(cfg.channel_count);
		end
	end

	assign c_cur  = ({1'b0, idx_q} >= n_used) ? '0 : idx_q;
	assign c_inc  = {1'b0, c_cur} + 1'b1;
	assign c_next = (c_inc >= n_used) ? '0 : c_inc[CW-1:0];
	assign k_last = ({1'b0, k_q} == n_used - 1'b1);

	// sample magnitude
	always_comb begin
		if (cfg.sample_bits < mplm_pkg::MIN_SAMPLE_BITS) begin
			bits_used = mplm_pkg::MIN_SAMPLE_BITS;
		end else if (cfg.sample_bits > mplm_pkg::MAX_SAMPLE_BITS) begin
			bits_used = mplm_pkg::MAX_SAMPLE_BITS;
		end else begin
			bits_used = cfg.sample_bits;
		end
		full_scale = 33'd1 << bits_used;
		half_scale = full_scale >> 1;
		raw        = {1'b0, samples.sample} & (full_scale - 33'd1);
		if (cfg.is_signed) begin
			mag = ((raw & half_scale) != '0) ? (full_scale - raw) : raw;
		end else begin
			mag = (raw >= half_scale) ? (raw - half_scale) : (half_scale - raw);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mplm_pkg::FS_RUN: begin
				if (valid_s1 && eob_s1) begin
					state_d = mplm_pkg::FS_DRAIN;
				end
			end
			mplm_pkg::FS_DRAIN: begin
				if (!q_full && k_last) begin
					state_d = mplm_pkg::FS_RUN;
				end
			end
			default: state_d = mplm_pkg::FS_RUN;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		q_push   = 1'b0;
		case (state_q)
			mplm_pkg::FS_RUN:   in_ready = !(valid_s1 && eob_s1);
			mplm_pkg::FS_DRAIN: q_push = !q_full;
			default: begin
				in_ready = 1'b0;
				q_push   = 1'b0;
			end
		endcase
	end

	assign samples.ready  = in_ready;
	assign accept         = samples.valid && in_ready;
	assign q_data.channel = 3'(k_q);
	assign q_data.peak    = peak_q[k_q];
	assign q_data.last    = k_last;

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1  <= mag[31:0];
			chan_s1 <= c_cur;
			eob_s1  <= samples.end_of_buffer;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= mplm_pkg::FS_RUN;
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			k_q      <= '0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				peak_q[i] <= '0;
			end
		end else begin
			state_q  <= state_d;
			valid_s1 <= accept;
			if (clear_peaks) begin
				idx_q <= '0;
			end else if (accept) begin
				idx_q <= samples.end_of_buffer ? '0 : c_next;
			end
			if (q_push) begin
				k_q <= k_last ? '0 : k_q + 1'b1;
			end
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				if (clear_peaks) begin
					peak_q[i] <= '0;
				end else if (q_push && k_q == CW'(i)) begin
					peak_q[i] <= '0;
				end else if (valid_s1 && chan_s1 == CW'(i) && mag_s1 > peak_q[i]) begin
					peak_q[i] <= mag_s1;
				end
			end
		end
	end

endmodule

[hw/rtl/mplm_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mplm_back
// turns queued peaks into bar graph reports: log2, scale, saturate, zone
// ----------------------------------------------------------------------------
module mplm_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mplm_pkg::cfg_t   cfg,
	input  logic             q_empty,
	input  mplm_pkg::entry_t q_data,
	output logic             q_pop,
	mplm_report_if.source    reports
);

	logic             en;
	logic [4:0]       lead;
	logic [31:0]      norm;
	logic [12:0]      log_d;
	logic [36:0]      mult;
	logic [37:0]      rounded;
	logic [14:0]      b_pct;
	logic [14:0]      n_yellow;
	logic [14:0]      n_orange;
	logic [14:0]      n_red;
	logic [1:0]       zone_d;

	logic             valid_s1, valid_s2, valid_s3;
	mplm_pkg::entry_t ent_s1, ent_s2, ent_s3;
	logic [12:0]      log_s1;
	logic [13:0]      prod_s2;
	logic [7:0]       lit_s3;

	logic             out_valid_q;
	mplm_pkg::entry_t out_ent_q;
	logic [7:0]       out_lit_q;
	logic [1:0]       out_zone_q;

	assign en    = !out_valid_q || reports.ready;
	assign q_pop = en && !q_empty;

	// q8 log2: leading one position and the eight bits below it
	always_comb begin
		lead = '0;
		for (int i = 0; i < 32; i++) begin
			if (q_data.peak[i]) begin
				lead = 5'(i);
			end
		end
		norm  = q_data.peak << (5'd31 - lead);
		log_d = {lead, norm[30:23]};
	end

	assign mult    = log_s1 * cfg.blocks_per_log2;
	assign rounded = {1'b0, mult} + 38'(24'h80_0000);

	// zone of the top lit block
	always_comb begin
		b_pct    = 15'(lit_s3 - 8'd1) * 15'(mplm_pkg::PCT_FULL);
		n_yellow = 15'(cfg.num_blocks) * 15'(mplm_pkg::PCT_YELLOW);
		n_orange = 15'(cfg.num_blocks) * 15'(mplm_pkg::PCT_ORANGE);
		n_red    = 15'(cfg.num_blocks) * 15'(mplm_pkg::PCT_RED);
		if (lit_s3 == '0) begin
			zone_d = mplm_pkg::ZONE_NORMAL;
		end else if (b_pct < n_yellow) begin
			zone_d = mplm_pkg::ZONE_NORMAL;
		end else if (b_pct < n_orange) begin
			zone_d = mplm_pkg::ZONE_YELLOW;
		end else if (b_pct < n_red) begin
			zone_d = mplm_pkg::ZONE_ORANGE;
		end else begin
			zone_d = mplm_pkg::ZONE_RED;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ent_s1     <= q_data;
			log_s1     <= log_d;
			ent_s2     <= ent_s1;
			prod_s2    <= rounded[37:24];
			ent_s3     <= ent_s2;
			lit_s3     <= (prod_s2 > 14'(cfg.num_blocks)) ? cfg.num_blocks : prod_s2[7:0];
			out_ent_q  <= ent_s3;
			out_lit_q  <= lit_s3;
			out_zone_q <= zone_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= !q_empty;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	assign reports.valid      = out_valid_q;
	assign reports.channel    = out_ent_q.channel;
	assign reports.peak       = out_ent_q.peak;
	assign reports.lit_blocks = out_lit_q;
	assign reports.zone       = out_zone_q;
	assign reports.last       = out_ent_q.last;

endmodule

[hw/rtl/multichannel_peak_level_meter.sv]
`timescale 1ns / 1ps
// flow: an accepted sample's magnitude is registered in mag_s1 before it updates its peak;
// an end of buffer sample drains the peaks as reports, one per cycle while ready is high
// throughput: one sample per cycle, except that an end of buffer sample holds input off
// while the peak registers drain, and longer if the report queue fills
// reset: arst_n clears all peaks, the channel index, the queue and the report pipeline
// and loads the register reset values (2 channels, 16 bit signed, 20 blocks)
// ----------------------------------------------------------------------------
// multichannel_peak_level_meter
// per-channel peak meter with a logarithmic bar graph report per buffer
// ----------------------------------------------------------------------------
`include "multichannel_peak_level_meter_macros.svh"

module multichannel_peak_level_meter #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mplm_sample_if.sink                     samples,
	mplm_report_if.source                   reports,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [mplm_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers, to be written by the user only while the meter is idle; the block does not enforce it
	mplm_pkg::cfg_t   cfg_q;
	logic             clear_peaks;

	// front to back report queue
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	mplm_pkg::entry_t q_push_data;
	mplm_pkg::entry_t q_head;

	// rewriting the channel count restarts all peaks and the channel rotation
	assign clear_peaks = cfg_we && (cfg_index == mplm_pkg::CFG_CHANNEL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count   <= mplm_pkg::RST_CHANNEL_COUNT;
			cfg_q.sample_bits     <= mplm_pkg::RST_SAMPLE_BITS;
			cfg_q.is_signed       <= mplm_pkg::RST_IS_SIGNED;
			cfg_q.num_blocks      <= mplm_pkg::RST_NUM_BLOCKS;
			cfg_q.blocks_per_log2 <= mplm_pkg::RST_BLOCKS_PER_LOG2;
		end else if (cfg_we) begin
			// indexes past the register list fall through and are ignored
			case (cfg_index)
				mplm_pkg::CFG_CHANNEL_COUNT:   cfg_q.channel_count   <= cfg_wdata[3:0];
				mplm_pkg::CFG_SAMPLE_BITS:     cfg_q.sample_bits     <= cfg_wdata[5:0];
				mplm_pkg::CFG_IS_SIGNED:       cfg_q.is_signed       <= cfg_wdata[0];
				mplm_pkg::CFG_NUM_BLOCKS:      cfg_q.num_blocks      <= cfg_wdata[7:0];
				mplm_pkg::CFG_BLOCKS_PER_LOG2: cfg_q.blocks_per_log2 <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// front: sample magnitude, per-channel peak tracking, drain on end of buffer
	mplm_front #(
		.MAX_CHANNELS(MAX_CHANNELS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples),
		.cfg         (cfg_q),
		.clear_peaks (clear_peaks),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_push_data)
	);

	// queue lets the drain run ahead while reports are stalled downstream
	mplm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.head      (q_head),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back: log2, scaling multiply, saturation and zone, output register
	mplm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_head),
		.q_pop   (q_pop),
		.reports (reports)
	);

	// a colored zone needs at least one lit block
	`MPLM_ASSERT_IMPLY(a_zone_needs_lit, clk, arst_n, reports.valid && reports.zone != mplm_pkg::ZONE_NORMAL, reports.lit_blocks != 8'd0, "zone set with no lit block")
	// the bar never exceeds its configured length
	`MPLM_ASSERT_IMPLY(a_lit_saturated, clk, arst_n, reports.valid, reports.lit_blocks <= cfg_q.num_blocks, "lit block count above bar length")
	// the drain only pushes into a queue with room
	`MPLM_ASSERT_IMPLY(a_no_push_when_full, clk, arst_n, q_push, !q_full, "report pushed into full queue")
	// after an end of buffer transaction the front stops taking samples
	`MPLM_ASSERT_NEXT(a_eob_stalls_input, clk, arst_n, samples.valid && samples.ready && samples.end_of_buffer, !samples.ready, "sample taken right after end of buffer")

endmodule
